### design/u8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
package u8sd_pkg;

    localparam int unsigned CP_W    = 31;
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    localparam logic [CP_W-1:0] REPL_CP       = 31'h0000FFFD;
    localparam logic [CP_W-1:0] SURR_LO       = 31'h0000D800;
    localparam logic [CP_W-1:0] SURR_HI       = 31'h0000DFFF;
    localparam logic [CP_W-1:0] NONCHAR_FFFE  = 31'h0000FFFE;
    localparam logic [CP_W-1:0] NONCHAR_FFFF  = 31'h0000FFFF;
    localparam logic [CP_W-1:0] MAX_LEN1      = 31'h0000007F;
    localparam logic [CP_W-1:0] MAX_LEN2      = 31'h000007FF;
    localparam logic [CP_W-1:0] MAX_LEN3      = 31'h0000FFFF;
    localparam logic [CP_W-1:0] MAX_LEN4      = 31'h001FFFFF;
    localparam logic [CP_W-1:0] MAX_LEN5      = 31'h03FFFFFF;

    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    // Classification of one byte taken while no sequence is open.
    typedef struct packed {
        logic            has_result;
        logic [CP_W-1:0] cp;
        logic            rep;
        logic [4:0]      bits;
        logic [2:0]      extra;
    } lead_t;

    // One queued command: the one or two results caused by one byte.
    typedef struct packed {
        logic            two;
        logic [CP_W-1:0] cp0;
        logic            rep0;
        logic            eos0;
        logic [CP_W-1:0] cp1;
        logic            rep1;
    } cmd_t;

endpackage

### design/u8sd_front.sv
// Front end: accepts bytes, tracks the open sequence and builds result commands.
module u8sd_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [7:0]         byte_in,
    output logic               cmd_valid,
    output u8sd_pkg::cmd_t     cmd
);

    logic [u8sd_pkg::CP_W-1:0] pv_reg, pv_next;
    logic [2:0]                bl_reg, bl_next;
    logic [2:0]                sl_reg, sl_next;

    u8sd_pkg::lead_t           ld;
    logic [u8sd_pkg::CP_W-1:0] pv_shift;
    logic [2:0]                bl_dec;
    logic                      bad;

    function automatic u8sd_pkg::lead_t classify(input logic [7:0] b);
        u8sd_pkg::lead_t r;
        r.has_result = 1'b0;
        r.cp         = '0;
        r.rep        = 1'b0;
        r.bits       = '0;
        r.extra      = '0;
        priority if (b[7] == 1'b0)
        begin
            r.has_result = 1'b1;
            r.cp         = {23'd0, b};
        end
        else if (b[7:5] == 3'b110)
        begin
            r.bits  = b[4:0];
            r.extra = 3'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            r.bits  = {1'b0, b[3:0]};
            r.extra = 3'd2;
        end
        else if (b[7:3] == 5'b11110)
        begin
            r.bits  = {2'b00, b[2:0]};
            r.extra = 3'd3;
        end
        else if (b[7:2] == 6'b111110)
        begin
            r.bits  = {3'b000, b[1:0]};
            r.extra = 3'd4;
        end
        else if (b[7:1] == 7'b1111110)
        begin
            r.bits  = {4'b0000, b[0]};
            r.extra = 3'd5;
        end
        else
        begin
            r.has_result = 1'b1;
            r.cp         = u8sd_pkg::REPL_CP;
            r.rep        = 1'b1;
        end
        return r;
    endfunction

    assign ld       = classify(byte_in);
    assign pv_shift = {pv_reg[u8sd_pkg::CP_W-7:0], byte_in[5:0]};
    assign bl_dec   = bl_reg - 3'd1;

    always_comb
    begin
        unique case (sl_reg)
            3'd2:    bad = (pv_shift <= u8sd_pkg::MAX_LEN1);
            3'd3:    bad = (pv_shift <= u8sd_pkg::MAX_LEN2)
                         || ((pv_shift >= u8sd_pkg::SURR_LO) && (pv_shift <= u8sd_pkg::SURR_HI))
                         || (pv_shift == u8sd_pkg::NONCHAR_FFFE)
                         || (pv_shift == u8sd_pkg::NONCHAR_FFFF);
            3'd4:    bad = (pv_shift <= u8sd_pkg::MAX_LEN3);
            3'd5:    bad = (pv_shift <= u8sd_pkg::MAX_LEN4);
            3'd6:    bad = (pv_shift <= u8sd_pkg::MAX_LEN5);
            default: bad = 1'b0;
        endcase
    end

    always_comb
    begin
        pv_next   = pv_reg;
        bl_next   = bl_reg;
        sl_next   = sl_reg;
        cmd_valid = 1'b0;
        cmd       = '0;
        priority if (byte_in == 8'd0)
        begin
            pv_next   = '0;
            bl_next   = '0;
            sl_next   = '0;
            cmd_valid = 1'b1;
            cmd.eos0  = 1'b1;
        end
        else if (bl_reg == 3'd0)
        begin
            if (ld.has_result)
            begin
                cmd_valid = 1'b1;
                cmd.cp0   = ld.cp;
                cmd.rep0  = ld.rep;
            end
            else
            begin
                pv_next = {26'd0, ld.bits};
                bl_next = ld.extra;
                sl_next = ld.extra + 3'd1;
            end
        end
        else if ((byte_in & u8sd_pkg::CONT_MASK) != u8sd_pkg::CONT_TAG)
        begin
            cmd_valid = 1'b1;
            cmd.cp0   = u8sd_pkg::REPL_CP;
            cmd.rep0  = 1'b1;
            if (ld.has_result)
            begin
                pv_next  = '0;
                bl_next  = '0;
                sl_next  = '0;
                cmd.two  = 1'b1;
                cmd.cp1  = ld.cp;
                cmd.rep1 = ld.rep;
            end
            else
            begin
                pv_next = {26'd0, ld.bits};
                bl_next = ld.extra;
                sl_next = ld.extra + 3'd1;
            end
        end
        else
        begin
            pv_next = pv_shift;
            bl_next = bl_dec;
            if (bl_dec == 3'd0)
            begin
                pv_next   = '0;
                sl_next   = '0;
                cmd_valid = 1'b1;
                cmd.cp0   = bad ? u8sd_pkg::REPL_CP : pv_shift;
                cmd.rep0  = bad;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
            bl_reg <= '0;
            sl_reg <= '0;
        end
        else if (take)
        begin
            pv_reg <= pv_next;
            bl_reg <= bl_next;
            sl_reg <= sl_next;
        end
    end

endmodule

### design/u8sd_queue.sv
// Command queue between the front end and the result stage.
module u8sd_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  u8sd_pkg::cmd_t     wr_data,
    output logic               q_full,
    input  logic               rd_en,
    output u8sd_pkg::cmd_t     rd_data,
    output logic               q_nempty
);

    u8sd_pkg::cmd_t                store_reg [u8sd_pkg::Q_DEPTH];
    logic [u8sd_pkg::Q_AW-1:0]     wp_reg, rp_reg;
    logic [u8sd_pkg::Q_AW:0]       cnt_reg, cnt_next;

    assign q_full   = (cnt_reg == (u8sd_pkg::Q_AW+1)'(u8sd_pkg::Q_DEPTH));
    assign q_nempty = (cnt_reg != '0);
    assign rd_data  = store_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        unique case ({wr_en, rd_en})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (rd_en)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

### design/u8sd_back.sv
// Result stage: expands commands into one or two results in an output register.
module u8sd_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_nempty,
    input  u8sd_pkg::cmd_t            head,
    output logic                      q_pop,
    input  logic                      pop,
    output logic                      empty,
    output logic [u8sd_pkg::CP_W-1:0] codepoint,
    output logic                      replaced,
    output logic                      end_of_string,
    output logic                      last
);

    logic                      valid_reg, valid_next;
    logic                      sec_reg, sec_next;
    logic [u8sd_pkg::CP_W-1:0] cp_reg, cp_next;
    logic                      rep_reg, rep_next;
    logic                      eos_reg, eos_next;
    logic                      last_reg, last_next;
    logic                      load;

    assign load  = !valid_reg || pop;
    assign q_pop = load && q_nempty && (sec_reg || !head.two);

    always_comb
    begin
        valid_next = valid_reg;
        sec_next   = sec_reg;
        cp_next    = cp_reg;
        rep_next   = rep_reg;
        eos_next   = eos_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = q_nempty;
            if (q_nempty)
            begin
                if (sec_reg)
                begin
                    sec_next  = 1'b0;
                    cp_next   = head.cp1;
                    rep_next  = head.rep1;
                    eos_next  = 1'b0;
                    last_next = 1'b1;
                end
                else
                begin
                    sec_next  = head.two;
                    cp_next   = head.cp0;
                    rep_next  = head.rep0;
                    eos_next  = head.eos0;
                    last_next = !head.two;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sec_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sec_reg   <= sec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg   <= cp_next;
        rep_reg  <= rep_next;
        eos_reg  <= eos_next;
        last_reg <= last_next;
    end

    assign empty         = !valid_reg;
    assign codepoint     = cp_reg;
    assign replaced      = rep_reg;
    assign end_of_string = eos_reg;
    assign last          = last_reg;

endmodule

### design/utf8_stream_decoder_unit.sv
// Top level of the UTF-8 (one to six byte) stream decoder.
//
// Input channel: one byte per transaction on byte_in, taken at a clock edge
// with push high and full low. Result channel: while empty is low the oldest
// result is on codepoint, replaced, end_of_string and last; pop takes it.
// A byte gives zero, one or two results; last marks the final one of a byte.
// A result passes through a queue entry, then the output register, before it
// is on the ports. Throughput: one byte per cycle while full is low; a byte
// that yields two results occupies the output register for each in turn, and
// the four-entry command queue absorbs that and any receiver stall.
// Once the queue is full, full rises and bytes are held off until the
// receiver pops. The decoder state advances only on accepted bytes.
// Reset clears the sequence state, the queue and the output valid flag, so
// empty is high and full is low after reset.
module utf8_stream_decoder_unit
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [7:0]                byte_in,
    output logic                      empty,
    input  logic                      pop,
    output logic [u8sd_pkg::CP_W-1:0] codepoint,
    output logic                      replaced,
    output logic                      end_of_string,
    output logic                      last
);

    logic           take;
    logic           cmd_valid;
    u8sd_pkg::cmd_t cmd;
    u8sd_pkg::cmd_t head;
    logic           q_full;
    logic           q_nempty;
    logic           q_pop;

    assign take = push && !q_full;
    assign full = q_full;

    u8sd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .byte_in   (byte_in),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    u8sd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (take && cmd_valid),
        .wr_data  (cmd),
        .q_full   (q_full),
        .rd_en    (q_pop),
        .rd_data  (head),
        .q_nempty (q_nempty)
    );

    u8sd_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_nempty      (q_nempty),
        .head          (head),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .codepoint     (codepoint),
        .replaced      (replaced),
        .end_of_string (end_of_string),
        .last          (last)
    );

endmodule

### design/u8sd_checker.sv
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
module u8sd_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      empty,
    input logic                      pop,
    input logic [u8sd_pkg::CP_W-1:0] codepoint,
    input logic                      replaced,
    input logic                      end_of_string,
    input logic                      last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(codepoint) && $stable(last)))
        else $error("result changed while stalled");

    a_eos: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && end_of_string) |->
            (codepoint == '0 && !replaced && last))
        else $error("end of string result malformed");

    a_repl: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && replaced) |-> (codepoint == u8sd_pkg::REPL_CP && !end_of_string))
        else $error("replacement result malformed");

    a_first_of_two: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last) |-> replaced)
        else $error("non-final result is not a replacement");

    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last && pop) |=> !empty)
        else $error("second result of a byte missing");

endmodule

bind utf8_stream_decoder_unit u8sd_checker u_u8sd_checker (.*);
